### hw/rtl/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

    // block header as kept in the header store
    typedef struct packed {
        logic [1:0]  typ;
        logic [15:0] size;
        logic [15:0] owner;
    } t_hdr;

    localparam logic [1:0] TYP_INVALID = 2'd0;
    localparam logic [1:0] TYP_INNER   = 2'd1;
    localparam logic [1:0] TYP_LAST    = 2'd2;

    localparam logic [2:0] OP_FORMAT   = 3'd0;
    localparam logic [2:0] OP_ALLOC    = 3'd1;
    localparam logic [2:0] OP_FREE     = 3'd2;
    localparam logic [2:0] OP_RESIZE   = 3'd3;
    localparam logic [2:0] OP_FREE_OWN = 3'd4;
    localparam logic [2:0] OP_WALK_F   = 3'd5;
    localparam logic [2:0] OP_WALK_N   = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LAST = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic CFG_ARENA_START = 1'b0;
    localparam logic CFG_ARENA_SIZE  = 1'b1;

    localparam logic [15:0] WALK_LIMIT_SEG = 16'hA000;
    localparam logic [15:0] NO_WALK        = 16'hFFFF;

    // header segment of the block that follows
    function automatic logic [15:0] next_seg(input logic [15:0] seg, input logic [15:0] size);
        return seg + size + 16'd1;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/bfa_ram.sv
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/best_fit_block_allocator_unit.sv
`default_nettype none
// Best-fit block allocator. The arena is a chain of block headers (type, size in
// paragraphs, owner) held in one single-port-write, registered-read header RAM of
// MAX_PARAGRAPHS entries; a sequencer runs one operation at a time by reading a
// header, modifying it and writing it back. Allocate walks the whole chain for
// the best fit; free runs a merge pass over the whole chain; resize stays in
// place or, when the block moves, runs an allocate and then a free; and
// free-by-owner walks the chain and runs one free for every block released.
// After reset a clearing pass marks every header invalid; no operation is
// taken during it, configuration writes are. One result beat follows every
// operation beat; a finished result waits in an output register while the
// next operation is accepted.
module best_fit_block_allocator_unit #(
    parameter int MAX_PARAGRAPHS = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    // operation channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_opcode,
    input  wire  [15:0] i_req_size,
    input  wire  [15:0] i_owner,
    input  wire  [15:0] i_segment,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_segment,
    output logic [15:0] o_block_size,
    output logic [15:0] o_block_owner,
    output logic        o_block_last
);
    import bfa_pkg::*;

    localparam int IW = $clog2(MAX_PARAGRAPHS);
    localparam int CW = $clog2(MAX_PARAGRAPHS + 3);
    localparam logic [CW-1:0] SCAN_LIMIT = CW'(MAX_PARAGRAPHS + 1);
    localparam logic [16:0]   MAX_P17    = 17'(MAX_PARAGRAPHS);

    typedef enum logic [26:0] {
        S_CLR     = 27'h0000001,
        S_IDLE    = 27'h0000002,
        S_DISP    = 27'h0000004,
        S_WALK    = 27'h0000008,
        S_WALK_Q  = 27'h0000010,
        S_WK_DONE = 27'h0000020,
        S_FB_CHK  = 27'h0000040,
        S_AL_RD   = 27'h0000080,
        S_AL_Q    = 27'h0000100,
        S_AL_WR   = 27'h0000200,
        S_AL_RET  = 27'h0000400,
        S_FR_RD   = 27'h0000800,
        S_FR_Q    = 27'h0001000,
        S_FR_NQ   = 27'h0002000,
        S_FR_RET  = 27'h0004000,
        S_MG_RD   = 27'h0008000,
        S_MG_Q    = 27'h0010000,
        S_MG_LOOP = 27'h0020000,
        S_MG_LQ   = 27'h0040000,
        S_MG_RET  = 27'h0080000,
        S_RS_Q    = 27'h0100000,
        S_RS_SH   = 27'h0200000,
        S_RS_GQ   = 27'h0400000,
        S_RS_GW   = 27'h0800000,
        S_FO_CHK  = 27'h1000000,
        S_FO_FRET = 27'h2000000,
        S_FIN     = 27'h4000000
    } t_state;

    // control registers
    t_state        r_state, n_state;
    logic [15:0]   r_cur, n_cur;            // walk cursor, shared by the walk, best-fit and free-by-owner scans
    logic [15:0]   r_arena_start;
    logic [12:0]   r_arena_size;
    logic [IW-1:0] r_clr;
    logic          r_ov;

    // operation payload and scratch
    logic [2:0]    r_op, n_op;
    logic [15:0]   r_req, n_req, r_own, n_own, r_seg, n_seg;
    logic [15:0]   r_a_seg, n_a_seg, r_b_seg, n_b_seg;
    t_hdr          r_a, n_a, r_b, n_b;
    logic [15:0]   r_wseg, n_wseg;
    t_hdr          r_wh, n_wh;
    logic [1:0]    r_wr, n_wr;
    logic [15:0]   r_best, n_best, r_slack, n_slack;
    logic          r_bok, n_bok;
    logic [CW-1:0] r_n, n_n, r_steps, n_steps, r_passes, n_passes;
    logic [15:0]   r_pid, n_pid, r_nseg, n_nseg, r_fseg, n_fseg;
    logic          r_mv, n_mv, r_ffail, n_ffail, r_fo_init, n_fo_init, r_fo_done, n_fo_done;
    logic          r_rd_ok;

    // result staging
    logic [1:0]    r_st, n_st;
    logic [15:0]   r_rs, n_rs, r_bsz, n_bsz, r_bown, n_bown;
    logic          r_blast, n_blast;

    // memory access
    logic          rd_en, wr_req, ram_we;
    logic [15:0]   rd_seg, wr_seg, rd_idx, wr_idx;
    t_hdr          wr_data, mem_hdr;
    logic [33:0]   ram_q, ram_wdata;
    logic [IW-1:0] ram_waddr;
    logic          rd_inr, wr_inr;

    // scratch in the sequencer
    t_state        wret;
    t_hdr          h;
    t_hdr          hm;
    logic [16:0]   fmt_n;
    logic [16:0]   room;
    logic [CW-1:0] cnt_inc;

    // header segments map to store entries relative to the arena start
    assign rd_idx = rd_seg - r_arena_start;
    assign wr_idx = wr_seg - r_arena_start;
    assign rd_inr = {1'b0, rd_idx} < MAX_P17;
    assign wr_inr = {1'b0, wr_idx} < MAX_P17;

    // an entry outside the store reads as an invalid header
    assign mem_hdr = r_rd_ok ? t_hdr'(ram_q) : t_hdr'('0);

    assign ram_we    = (r_state == S_CLR) || (wr_req && wr_inr);
    assign ram_waddr = (r_state == S_CLR) ? r_clr : wr_idx[IW-1:0];
    assign ram_wdata = (r_state == S_CLR) ? 34'd0 : 34'(wr_data);

    bfa_ram #(
        .WIDTH ($bits(t_hdr)),
        .DEPTH (MAX_PARAGRAPHS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_idx[IW-1:0]),
        .o_rdata (ram_q)
    );

    assign o_in_stall = (r_state != S_IDLE);

    // where a finished walk step goes back to
    always_comb begin
        if (r_op == OP_WALK_F || r_op == OP_WALK_N) begin
            wret = S_WK_DONE;
        end else if (r_op == OP_FREE_OWN) begin
            wret = S_FO_CHK;
        end else begin
            wret = S_FB_CHK;
        end
    end

    always_comb begin
        n_state = r_state;   n_cur = r_cur;
        n_op = r_op;         n_req = r_req;       n_own = r_own;     n_seg = r_seg;
        n_a_seg = r_a_seg;   n_b_seg = r_b_seg;   n_a = r_a;         n_b = r_b;
        n_wseg = r_wseg;     n_wh = r_wh;         n_wr = r_wr;
        n_best = r_best;     n_slack = r_slack;   n_bok = r_bok;
        n_n = r_n;           n_steps = r_steps;   n_passes = r_passes;
        n_pid = r_pid;       n_nseg = r_nseg;     n_fseg = r_fseg;
        n_mv = r_mv;         n_ffail = r_ffail;   n_fo_init = r_fo_init;
        n_fo_done = r_fo_done;
        n_st = r_st;         n_rs = r_rs;         n_bsz = r_bsz;
        n_bown = r_bown;     n_blast = r_blast;
        rd_en = 1'b0;        rd_seg = '0;
        wr_req = 1'b0;       wr_seg = '0;         wr_data = '0;
        h = mem_hdr;         hm = '0;
        fmt_n = '0;          room = '0;           cnt_inc = '0;

        unique case (r_state)
            S_CLR: begin
                if (r_clr == IW'(MAX_PARAGRAPHS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    n_req = i_req_size;
                    n_own = i_owner;
                    n_seg = i_segment;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_st = ST_OK; n_rs = '0; n_bsz = '0; n_bown = '0; n_blast = 1'b0;
                n_mv = 1'b0;
                unique case (r_op)
                    OP_FORMAT: begin
                        fmt_n = {4'd0, r_arena_size};
                        if (fmt_n == 17'd0) begin
                            fmt_n = 17'd1;
                        end
                        if (fmt_n > MAX_P17) begin
                            fmt_n = MAX_P17;
                        end
                        wr_req = 1'b1;
                        wr_seg = r_arena_start;
                        wr_data = '{typ: TYP_LAST, size: 16'(fmt_n - 17'd1), owner: 16'd0};
                        n_cur = NO_WALK;
                        n_state = S_FIN;
                    end
                    OP_ALLOC: begin
                        if (r_req == 16'd0) begin
                            n_st = ST_FAIL;
                            n_state = S_FIN;
                        end else begin
                            n_pid = r_own;
                            n_slack = 16'hFFFF; n_bok = 1'b0; n_n = '0;
                            n_cur = r_arena_start;
                            n_state = S_WALK;
                        end
                    end
                    OP_FREE: begin
                        n_fseg = r_seg;
                        n_state = S_FR_RD;
                    end
                    OP_RESIZE: begin
                        if (r_seg == 16'd0 || r_req == 16'd0) begin
                            n_st = ST_FAIL;
                            n_state = S_FIN;
                        end else begin
                            n_a_seg = r_seg - 16'd1;
                            rd_en = 1'b1;
                            rd_seg = r_seg - 16'd1;
                            n_state = S_RS_Q;
                        end
                    end
                    OP_FREE_OWN: begin
                        if (r_own < 16'd2) begin
                            n_state = S_FIN;
                        end else begin
                            n_passes = '0; n_steps = '0;
                            n_fo_init = 1'b1; n_fo_done = 1'b0;
                            n_cur = r_arena_start;
                            n_state = S_WALK;
                        end
                    end
                    OP_WALK_F: begin
                        n_cur = r_arena_start;
                        n_state = S_WALK;
                    end
                    OP_WALK_N: begin
                        n_state = S_WALK;
                    end
                    default: begin
                        n_st = ST_FAIL;
                        n_state = S_FIN;
                    end
                endcase
            end
            // one step of the chain cursor
            S_WALK: begin
                if (r_cur >= WALK_LIMIT_SEG) begin
                    n_wr = ST_FAIL;
                    n_state = wret;
                end else begin
                    rd_en = 1'b1;
                    rd_seg = r_cur;
                    n_wseg = r_cur;
                    n_state = S_WALK_Q;
                end
            end
            S_WALK_Q: begin
                n_wh = h;
                if (h.typ == TYP_INNER) begin
                    n_cur = next_seg(r_wseg, h.size);
                    n_wr = ST_OK;
                end else if (h.typ == TYP_LAST) begin
                    n_cur = NO_WALK;
                    n_wr = ST_LAST;
                end else begin
                    n_wr = ST_FAIL;
                end
                n_state = wret;
            end
            S_WK_DONE: begin
                n_st = r_wr;
                if (r_wr != ST_FAIL) begin
                    n_rs = r_wseg;
                    n_bsz = r_wh.size;
                    n_bown = r_wh.owner;
                    n_blast = (r_wh.typ == TYP_LAST);
                end
                n_state = S_FIN;
            end
            // best-fit search, earliest block wins a tie
            S_FB_CHK: begin
                if (r_wr != ST_FAIL && r_n < SCAN_LIMIT) begin
                    if (r_wh.owner == 16'd0 && r_wh.size >= r_req &&
                        r_slack > (r_wh.size - r_req)) begin
                        n_slack = r_wh.size - r_req;
                        n_best = r_wseg;
                        n_bok = 1'b1;
                    end
                    n_n = r_n + CW'(1);
                    n_state = S_WALK;
                end else if (r_bok) begin
                    n_state = S_AL_RD;
                end else begin
                    n_state = S_AL_RET;
                end
            end
            S_AL_RD: begin
                rd_en = 1'b1;
                rd_seg = r_best;
                n_state = S_AL_Q;
            end
            S_AL_Q: begin
                hm = h;
                if (r_req < h.size) begin
                    wr_req = 1'b1;
                    wr_seg = next_seg(r_best, r_req);
                    wr_data = '{typ: h.typ, size: h.size - r_req - 16'd1, owner: 16'd0};
                    hm.typ = TYP_INNER;
                end
                hm.size = r_req;
                hm.owner = (r_pid != 16'd0) ? r_pid : (r_best + 16'd1);
                n_a = hm;
                n_nseg = r_best + 16'd1;
                n_state = S_AL_WR;
            end
            S_AL_WR: begin
                wr_req = 1'b1;
                wr_seg = r_best;
                wr_data = r_a;
                n_state = S_AL_RET;
            end
            S_AL_RET: begin
                if (!r_bok) begin
                    n_st = ST_FAIL;
                    n_state = S_FIN;
                end else if (r_op == OP_ALLOC) begin
                    n_rs = r_nseg;
                    n_state = S_FIN;
                end else begin
                    // moved: release the old block
                    n_fseg = r_seg;
                    n_state = S_FR_RD;
                end
            end
            // free one block, absorbing a free follower
            S_FR_RD: begin
                n_ffail = 1'b0;
                if (r_fseg == 16'd0) begin
                    n_ffail = 1'b1;
                    n_state = S_FR_RET;
                end else begin
                    rd_en = 1'b1;
                    rd_seg = r_fseg - 16'd1;
                    n_a_seg = r_fseg - 16'd1;
                    n_state = S_FR_Q;
                end
            end
            S_FR_Q: begin
                hm = h;
                hm.owner = 16'd0;
                n_a = hm;
                if (h.typ == TYP_INVALID) begin
                    n_ffail = 1'b1;
                    n_state = S_FR_RET;
                end else if (h.typ == TYP_LAST) begin
                    wr_req = 1'b1;
                    wr_seg = r_a_seg;
                    wr_data = hm;
                    n_state = S_MG_RD;
                end else begin
                    rd_en = 1'b1;
                    rd_seg = next_seg(r_a_seg, h.size);
                    n_state = S_FR_NQ;
                end
            end
            S_FR_NQ: begin
                hm = r_a;
                if (h.typ != TYP_INVALID && h.owner == 16'd0) begin
                    hm.size = r_a.size + h.size + 16'd1;
                    hm.typ = h.typ;
                end
                wr_req = 1'b1;
                wr_seg = r_a_seg;
                wr_data = hm;
                n_state = S_MG_RD;
            end
            S_FR_RET: begin
                if (r_op == OP_FREE) begin
                    n_st = r_ffail ? ST_FAIL : ST_OK;
                    n_state = S_FIN;
                end else if (r_op == OP_RESIZE) begin
                    n_rs = r_nseg;
                    n_state = S_FIN;
                end else begin
                    n_state = S_FO_FRET;
                end
            end
            // merge pass over the whole chain
            S_MG_RD: begin
                rd_en = 1'b1;
                rd_seg = r_arena_start;
                n_a_seg = r_arena_start;
                n_state = S_MG_Q;
            end
            S_MG_Q: begin
                if (h.typ != TYP_INNER) begin
                    n_state = S_MG_RET;
                end else begin
                    n_a = h;
                    n_b = h;
                    n_b_seg = r_a_seg;
                    n_n = '0;
                    n_state = S_MG_LOOP;
                end
            end
            S_MG_LOOP: begin
                if (r_n >= SCAN_LIMIT) begin
                    n_state = S_MG_RET;
                end else begin
                    n_b_seg = next_seg(r_b_seg, r_b.size);
                    rd_en = 1'b1;
                    rd_seg = next_seg(r_b_seg, r_b.size);
                    n_state = S_MG_LQ;
                end
            end
            S_MG_LQ: begin
                if (h.typ == TYP_INVALID) begin
                    n_state = S_MG_RET;
                end else begin
                    if (r_a.owner == 16'd0 && h.owner == 16'd0) begin
                        hm = '{typ: h.typ, size: r_a.size + h.size + 16'd1, owner: r_a.owner};
                        n_a = hm;
                        wr_req = 1'b1;
                        wr_seg = r_a_seg;
                        wr_data = hm;
                    end else begin
                        n_a_seg = r_b_seg;
                        n_a = h;
                    end
                    n_b = h;
                    n_n = r_n + CW'(1);
                    n_state = (h.typ == TYP_LAST) ? S_MG_RET : S_MG_LOOP;
                end
            end
            S_MG_RET: begin
                if (r_op == OP_RESIZE && !r_mv) begin
                    n_rs = r_seg;
                    n_state = S_FIN;
                end else begin
                    n_state = S_FR_RET;
                end
            end
            // resize: shrink, grow in place or move
            S_RS_Q: begin
                n_a = h;
                if (h.typ == TYP_INVALID) begin
                    n_st = ST_FAIL;
                    n_state = S_FIN;
                end else if (r_req == h.size) begin
                    n_rs = r_seg;
                    n_state = S_FIN;
                end else if (r_req < h.size) begin
                    wr_req = 1'b1;
                    wr_seg = r_a_seg;
                    wr_data = '{typ: TYP_INNER, size: r_req, owner: h.owner};
                    n_b = '{typ: h.typ, size: h.size - r_req - 16'd1, owner: 16'd0};
                    n_state = S_RS_SH;
                end else if (h.typ == TYP_INNER) begin
                    rd_en = 1'b1;
                    rd_seg = next_seg(r_a_seg, h.size);
                    n_state = S_RS_GQ;
                end else begin
                    n_pid = h.owner;
                    n_mv = 1'b1;
                    n_slack = 16'hFFFF; n_bok = 1'b0; n_n = '0;
                    n_cur = r_arena_start;
                    n_state = S_WALK;
                end
            end
            S_RS_SH: begin
                wr_req = 1'b1;
                wr_seg = next_seg(r_a_seg, r_req);
                wr_data = r_b;
                n_state = S_MG_RD;
            end
            S_RS_GQ: begin
                room = {1'b0, h.size} + {1'b0, r_a.size} + 17'd1;
                if (h.typ != TYP_INVALID && h.owner == 16'd0 && room >= {1'b0, r_req}) begin
                    if (room > {1'b0, r_req}) begin
                        wr_req = 1'b1;
                        wr_seg = next_seg(r_a_seg, r_req);
                        wr_data = '{typ: h.typ, size: 16'(room - {1'b0, r_req} - 17'd1),
                                    owner: 16'd0};
                        n_a = '{typ: r_a.typ, size: r_req, owner: r_a.owner};
                    end else begin
                        n_a = '{typ: h.typ, size: r_req, owner: r_a.owner};
                    end
                    n_state = S_RS_GW;
                end else begin
                    n_pid = r_a.owner;
                    n_mv = 1'b1;
                    n_slack = 16'hFFFF; n_bok = 1'b0; n_n = '0;
                    n_cur = r_arena_start;
                    n_state = S_WALK;
                end
            end
            S_RS_GW: begin
                wr_req = 1'b1;
                wr_seg = r_a_seg;
                wr_data = r_a;
                n_rs = r_seg;
                n_state = S_FIN;
            end
            // free-by-owner: rescan from the start after every release
            S_FO_CHK: begin
                n_fo_init = 1'b0;
                if ((r_fo_init && r_wr == ST_FAIL) || r_fo_done) begin
                    n_state = S_FIN;
                end else begin
                    n_fo_done = (r_wr != ST_OK);
                    if (r_wr != ST_FAIL && r_wh.owner == r_own) begin
                        n_fseg = r_wseg + 16'd1;
                        n_state = S_FR_RD;
                    end else begin
                        cnt_inc = r_steps + CW'(1);
                        n_steps = cnt_inc;
                        n_state = (cnt_inc > SCAN_LIMIT) ? S_FIN : S_WALK;
                    end
                end
            end
            S_FO_FRET: begin
                cnt_inc = r_passes + CW'(1);
                n_passes = cnt_inc;
                if (cnt_inc > SCAN_LIMIT) begin
                    n_state = S_FIN;
                end else begin
                    n_steps = '0;
                    n_cur = r_arena_start;
                    n_state = S_WALK;
                end
            end
            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_cur         <= NO_WALK;
            r_arena_start <= 16'd0;
            r_arena_size  <= 13'd4096;
            r_clr         <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ARENA_START) begin
                    r_arena_start <= i_cfg_data;
                end else begin
                    r_arena_size <= i_cfg_data[12:0];
                end
            end
            // result register: load on finish, drop when taken
            if (r_state == S_FIN && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and scratch
    always_ff @(posedge i_clk) begin
        r_op <= n_op;           r_req <= n_req;       r_own <= n_own;     r_seg <= n_seg;
        r_a_seg <= n_a_seg;     r_b_seg <= n_b_seg;   r_a <= n_a;         r_b <= n_b;
        r_wseg <= n_wseg;       r_wh <= n_wh;         r_wr <= n_wr;
        r_best <= n_best;       r_slack <= n_slack;   r_bok <= n_bok;
        r_n <= n_n;             r_steps <= n_steps;   r_passes <= n_passes;
        r_pid <= n_pid;         r_nseg <= n_nseg;     r_fseg <= n_fseg;
        r_mv <= n_mv;           r_ffail <= n_ffail;   r_fo_init <= n_fo_init;
        r_fo_done <= n_fo_done;
        r_st <= n_st;           r_rs <= n_rs;         r_bsz <= n_bsz;
        r_bown <= n_bown;       r_blast <= n_blast;
        r_rd_ok <= rd_inr;
        if (r_state == S_FIN && (!r_ov || !i_out_stall)) begin
            o_status         <= r_st;
            o_result_segment <= r_rs;
            o_block_size     <= r_bsz;
            o_block_owner    <= r_bown;
            o_block_last     <= r_blast;
        end
    end

    assign o_out_valid = r_ov;

`ifndef ASSERT_OFF
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && ram_we))
        else $error("header read and write issued in the same cycle");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("header store written while idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MG_LOOP || r_state == S_FB_CHK) |-> (r_n <= SCAN_LIMIT))
        else $error("chain scan count beyond bound");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result beat raised outside finish");
`endif
endmodule
`default_nettype wire

### verif/best_fit_block_allocator_unit_tb.sv
`default_nettype none
module best_fit_block_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfa_pkg::*;

    localparam int MAXP         = 4096;
    localparam int SCAN_MAX     = MAXP + 1;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rseg;
        logic [15:0] bsize;
        logic [15:0] bowner;
        logic        blast;
    } t_op_result;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] req;
        logic [15:0] own;
        logic [15:0] seg;
        bit          typed;
        t_op_result  res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_opcode = '0;
    logic [15:0] i_req_size = '0;
    logic [15:0] i_owner = '0;
    logic [15:0] i_segment = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_result_segment;
    logic [15:0] o_block_size;
    logic [15:0] o_block_owner;
    logic        o_block_last;

    best_fit_block_allocator_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // allocator model state
    // ---------------------------------------------------------------
    t_hdr        hdr_mem [MAXP];
    logic [15:0] walk_pos;
    logic [15:0] start_reg;
    logic [12:0] size_reg;

    t_op_result  pending_results[$];
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;

    function automatic t_hdr hdr_rd(input logic [15:0] seg);
        logic [15:0] idx;
        t_hdr h;
        idx = seg - start_reg;
        h = '0;
        if (idx < MAXP) h = hdr_mem[idx];
        return h;
    endfunction

    function automatic void hdr_wr(input logic [15:0] seg, input t_hdr h);
        logic [15:0] idx;
        idx = seg - start_reg;
        if (idx < MAXP) hdr_mem[idx] = h;
    endfunction

    function automatic logic [15:0] follow(input logic [15:0] seg, input logic [15:0] sz);
        return seg + sz + 16'd1;
    endfunction

    // one step of the chain cursor
    function automatic logic [1:0] walk_step(input bit first, output t_hdr h,
                                             output logic [15:0] seg);
        h = '0;
        seg = '0;
        if (first) walk_pos = start_reg;
        if (walk_pos >= WALK_LIMIT_SEG) return ST_FAIL;
        seg = walk_pos;
        h = hdr_rd(walk_pos);
        if (h.typ == TYP_INNER) begin
            walk_pos = follow(walk_pos, h.size);
            return ST_OK;
        end
        if (h.typ == TYP_LAST) begin
            walk_pos = NO_WALK;
            return ST_LAST;
        end
        return ST_FAIL;
    endfunction

    function automatic void merge_all_free();
        logic [15:0] s1, s2;
        t_hdr m1, m2;
        s1 = start_reg;
        m1 = hdr_rd(s1);
        if (m1.typ != TYP_INNER) return;
        s2 = s1;
        m2 = m1;
        for (int n = 0; n < SCAN_MAX; n++) begin
            s2 = follow(s2, m2.size);
            m2 = hdr_rd(s2);
            if (m2.typ == TYP_INVALID) return;
            if (m1.owner == 0 && m2.owner == 0) begin
                m1.size = m1.size + m2.size + 16'd1;
                m1.typ = m2.typ;
                hdr_wr(s1, m1);
            end else begin
                s1 = s2;
                m1 = m2;
            end
            if (m2.typ == TYP_LAST) return;
        end
    endfunction

    function automatic bit find_best_fit(input logic [15:0] req, output logic [15:0] found);
        t_hdr h;
        logic [15:0] s, slack;
        logic [1:0] r;
        bit ok;
        int n;
        slack = 16'hFFFF;
        ok = 1'b0;
        n = 0;
        found = '0;
        r = walk_step(1'b1, h, s);
        while (r != ST_FAIL && n < SCAN_MAX) begin
            if (h.owner == 0 && h.size >= req && slack > 16'(h.size - req)) begin
                slack = h.size - req;
                found = s;
                ok = 1'b1;
            end
            r = walk_step(1'b0, h, s);
            n++;
        end
        return ok;
    endfunction

    function automatic bit alloc_block(input logic [15:0] req, input logic [15:0] pid,
                                       output logic [15:0] dseg);
        logic [15:0] hseg;
        t_hdr c, rest;
        dseg = '0;
        if (req == 0) return 1'b0;
        if (!find_best_fit(req, hseg)) return 1'b0;
        c = hdr_rd(hseg);
        if (req < c.size) begin
            rest.size = c.size - req - 16'd1;
            rest.owner = '0;
            rest.typ = c.typ;
            c.typ = TYP_INNER;
            hdr_wr(follow(hseg, req), rest);
        end
        c.size = req;
        dseg = hseg + 16'd1;
        c.owner = (pid != 0) ? pid : dseg;
        hdr_wr(hseg, c);
        return 1'b1;
    endfunction

    function automatic bit free_block(input logic [15:0] seg);
        logic [15:0] hseg;
        t_hdr c, nx;
        if (seg == 0) return 1'b0;
        hseg = seg - 16'd1;
        c = hdr_rd(hseg);
        if (c.typ == TYP_INVALID) return 1'b0;
        c.owner = '0;
        if (c.typ != TYP_LAST) begin
            nx = hdr_rd(follow(hseg, c.size));
            if (nx.typ != TYP_INVALID && nx.owner == 0) begin
                c.size = c.size + nx.size + 16'd1;
                c.typ = nx.typ;
            end
        end
        hdr_wr(hseg, c);
        merge_all_free();
        return 1'b1;
    endfunction

    function automatic bit resize_block(input logic [15:0] req, input logic [15:0] seg,
                                        output logic [15:0] res);
        logic [15:0] hseg, nseg;
        t_hdr b, nx;
        logic [16:0] room;
        res = '0;
        if (seg == 0 || req == 0) return 1'b0;
        hseg = seg - 16'd1;
        b = hdr_rd(hseg);
        if (b.typ == TYP_INVALID) return 1'b0;
        res = seg;
        if (req == b.size) return 1'b1;
        // shrink in place, the tail becomes a free block
        if (req < b.size) begin
            nx.size = b.size - req - 16'd1;
            nx.owner = '0;
            nx.typ = b.typ;
            b.typ = TYP_INNER;
            b.size = req;
            hdr_wr(hseg, b);
            hdr_wr(follow(hseg, req), nx);
            merge_all_free();
            return 1'b1;
        end
        // grow into a free neighbour, never for a last block
        if (b.typ == TYP_INNER) begin
            nx = hdr_rd(follow(hseg, b.size));
            room = 17'(nx.size) + 17'(b.size) + 17'd1;
            if (nx.typ != TYP_INVALID && nx.owner == 0 && room >= 17'(req)) begin
                b.size = req;
                if (room > 17'(req)) begin
                    nx.owner = '0;
                    nx.size = 16'(room - 17'(req) - 17'd1);
                    hdr_wr(follow(hseg, req), nx);
                end else begin
                    b.typ = nx.typ;
                end
                hdr_wr(hseg, b);
                return 1'b1;
            end
        end
        // move
        if (!alloc_block(req, b.owner, nseg)) return 1'b0;
        void'(free_block(seg));
        res = nseg;
        return 1'b1;
    endfunction

    function automatic void release_owner(input logic [15:0] pid);
        t_hdr h;
        logic [15:0] s;
        logic [1:0] r;
        int steps, passes;
        bit done;
        steps = 0;
        passes = 0;
        done = 1'b0;
        if (pid < 2) return;
        r = walk_step(1'b1, h, s);
        if (r == ST_FAIL) return;
        while (!done) begin
            if (r != ST_OK) done = 1'b1;
            if (r != ST_FAIL && h.owner == pid) begin
                void'(free_block(s + 16'd1));
                passes++;
                if (passes > SCAN_MAX) return;
                steps = 0;
                r = walk_step(1'b1, h, s);
            end else begin
                steps++;
                if (steps > SCAN_MAX) return;
                r = walk_step(1'b0, h, s);
            end
        end
    endfunction

    function automatic t_op_result predict_op(input logic [2:0] op, input logic [15:0] req,
                                              input logic [15:0] own, input logic [15:0] seg);
        t_op_result o;
        t_hdr h;
        logic [15:0] rs;
        logic [1:0] r;
        int n;
        o = '0;
        case (op)
            OP_FORMAT: begin
                n = size_reg;
                if (n < 1) n = 1;
                if (n > MAXP) n = MAXP;
                h.typ = TYP_LAST;
                h.size = 16'(n - 1);
                h.owner = '0;
                hdr_wr(start_reg, h);
                walk_pos = NO_WALK;
            end
            OP_ALLOC: begin
                if (alloc_block(req, own, rs)) o.rseg = rs;
                else o.status = ST_FAIL;
            end
            OP_FREE: begin
                if (!free_block(seg)) o.status = ST_FAIL;
            end
            OP_RESIZE: begin
                if (resize_block(req, seg, rs)) o.rseg = rs;
                else o.status = ST_FAIL;
            end
            OP_FREE_OWN: release_owner(own);
            OP_WALK_F, OP_WALK_N: begin
                r = walk_step(op == OP_WALK_F, h, rs);
                o.status = r;
                if (r != ST_FAIL) begin
                    o.rseg = rs;
                    o.bsize = h.size;
                    o.bowner = h.owner;
                    o.blast = (h.typ == TYP_LAST);
                end
            end
            default: o.status = ST_FAIL;
        endcase
        return o;
    endfunction

    // data segment of an owned block, or a random one; a side scan keeps the cursor
    function automatic logic [15:0] pick_owned_block();
        logic [15:0] s, segs[$];
        t_hdr h;
        s = start_reg;
        for (int n = 0; n < SCAN_MAX; n++) begin
            if (s >= WALK_LIMIT_SEG) break;
            h = hdr_rd(s);
            if (h.typ == TYP_INVALID) break;
            if (h.owner != 0) segs.push_back(s + 16'd1);
            if (h.typ == TYP_LAST) break;
            s = follow(s, h.size);
        end
        if (segs.size() == 0) return 16'(1 + $urandom_range(0, 300));
        return segs[$urandom_range(0, segs.size() - 1)];
    endfunction

    // ---------------------------------------------------------------
    // operation driver
    // ---------------------------------------------------------------
    task automatic send_op(input logic [2:0] op, input logic [15:0] req, input logic [15:0] own,
                           input logic [15:0] seg, input bit typed, input t_op_result want);
        t_op_result pred;
        // random gaps before the beat
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_req_size <= req;
        i_owner    <= own;
        i_segment  <= seg;
        do @(posedge i_clk); while (o_in_stall);
        // beat taken at this edge
        pred = predict_op(op, req, own, seg);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_ARENA_START) start_reg = data;
        else size_reg = data[12:0];
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(1, 64));
        if (r < 96) return 16'($urandom_range(1, 600));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_owner();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 6));
    endfunction

    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      send_op(OP_ALLOC, rand_size(), rand_owner(), 16'($urandom), 0, '0);
        else if (r < 50) send_op(OP_FREE, 16'($urandom), 16'($urandom), pick_owned_block(), 0, '0);
        else if (r < 64) send_op(OP_RESIZE, rand_size(), 16'($urandom), pick_owned_block(), 0, '0);
        else if (r < 69) send_op(OP_FREE_OWN, 16'($urandom), rand_owner(), 16'($urandom), 0, '0);
        else if (r < 76) send_op(OP_WALK_F, 16'($urandom), 16'($urandom), 16'($urandom), 0, '0);
        else if (r < 89) send_op(OP_WALK_N, 16'($urandom), 16'($urandom), 16'($urandom), 0, '0);
        else if (r < 91) send_op(OP_FORMAT, 16'($urandom), 16'($urandom), 16'($urandom), 0, '0);
        // noise: stray segments and the unused opcode
        else if (r < 95) send_op(3'($urandom_range(2, 3)), 16'($urandom), 16'($urandom),
                                 16'($urandom), 0, '0);
        else             send_op(3'd7, 16'($urandom), 16'($urandom), 16'($urandom), 0, '0);
    endtask

    // ---------------------------------------------------------------
    // result side: stall pattern and checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) hold_cnt = 600;
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            if (hold_cnt == 0) hold_req = 1'b0;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_op_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending", $time);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("result_segment", want.rseg, o_result_segment);
                check_field("block_size", want.bsize, o_block_size);
                check_field("block_owner", want.bowner, o_block_owner);
                check_field("block_last", 16'(want.blast), 16'(o_block_last));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed rows, then random phases
    // ---------------------------------------------------------------
    t_dir_row dir_tab[$];

    initial begin
        logic [15:0] starts[NUM_PHASES];
        logic [15:0] sizes[NUM_PHASES];
        foreach (hdr_mem[k]) hdr_mem[k] = '0;
        walk_pos  = NO_WALK;
        start_reg = '0;
        size_reg  = 13'd4096;
        starts = '{16'h0000, 16'hFFFF, 16'h1234, 16'h9F80, 16'h0000, 16'hF000, 16'h8000, 16'h0000};
        sizes  = '{16'd4096, 16'd1, 16'd700, 16'd8191, 16'd2000, 16'd160, 16'd4096, 16'd300};

        // walks on an unformatted store, unknown opcode, format, alloc extremes
        dir_tab.push_back('{OP_WALK_F, 0, 0, 0, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_WALK_N, 0, 0, 0, 0, '0});
        dir_tab.push_back('{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_FORMAT, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_WALK_F, 0, 0, 0, 1, '{ST_LAST, 0, 4095, 0, 1}});
        dir_tab.push_back('{OP_ALLOC, 0, 3, 0, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_ALLOC, 16'hFFFF, 3, 0, 1, '{ST_FAIL, 0, 0, 0, 0}});
        // owner 0 makes the block own itself
        dir_tab.push_back('{OP_ALLOC, 100, 0, 0, 1, '{ST_OK, 1, 0, 0, 0}});
        dir_tab.push_back('{OP_ALLOC, 200, 16'hFFFF, 0, 1, '{ST_OK, 102, 0, 0, 0}});
        dir_tab.push_back('{OP_ALLOC, 50, 5, 0, 0, '0});
        dir_tab.push_back('{OP_FREE, 0, 0, 0, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_FREE, 0, 0, 16'hFFFF, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_RESIZE, 10, 0, 0, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_RESIZE, 0, 0, 1, 1, '{ST_FAIL, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_RESIZE, 100, 0, 1, 1, '{ST_OK, 1, 0, 0, 0}});
        // shrink, then move since the neighbour is owned
        dir_tab.push_back('{OP_RESIZE, 40, 0, 1, 0, '0});
        dir_tab.push_back('{OP_RESIZE, 300, 0, 102, 0, '0});
        dir_tab.push_back('{OP_FREE_OWN, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_FREE_OWN, 0, 1, 0, 1, '{ST_OK, 0, 0, 0, 0}});
        dir_tab.push_back('{OP_FREE_OWN, 0, 16'hFFFF, 0, 0, '0});
        dir_tab.push_back('{OP_WALK_F, 0, 0, 0, 0, '0});
        dir_tab.push_back('{OP_WALK_N, 0, 0, 0, 0, '0});
        dir_tab.push_back('{OP_WALK_N, 0, 0, 0, 0, '0});
        // grow into the free neighbour, then free the rest
        dir_tab.push_back('{OP_RESIZE, 90, 0, 1, 0, '0});
        dir_tab.push_back('{OP_FREE_OWN, 0, 5, 0, 0, '0});
        dir_tab.push_back('{OP_FREE, 0, 0, 1, 0, '0});
        dir_tab.push_back('{OP_WALK_F, 0, 0, 0, 0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            send_op(dir_tab[k].op, dir_tab[k].req, dir_tab[k].own, dir_tab[k].seg,
                    dir_tab[k].typed, dir_tab[k].res);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_write(CFG_ARENA_START, starts[p]);
            cfg_write(CFG_ARENA_SIZE, sizes[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            // long receiver hold-off while beats keep coming
            if (p == 4) hold_req = 1'b1;
            send_op(OP_FORMAT, 16'($urandom), 16'($urandom), 16'($urandom), 0, '0);
            for (int k = 0; k < PHASE_ITEMS; k++) send_random();
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/best_fit_block_allocator_unit.sv
verif/best_fit_block_allocator_unit_tb.sv
